// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int SPQ_CAPACITY = 16;

   // Request modes.
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_LIST   = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
      logic [15:0]        priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value_res;
      logic [15:0]        priority_out;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [15:0]        prio;
   } entry_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE,
      OP_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   entry;
   } cell_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_LIST
   } state_type;

endpackage

`default_nettype wire

// ===== design/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  spq_pkg::cell_cmd_type cmd,
   input  logic                 left_valid,
   input  logic                 left_keep,
   input  spq_pkg::entry_type   left_entry,
   input  logic                 right_valid,
   input  spq_pkg::entry_type   right_entry,
   input  spq_pkg::entry_type   head_entry,
   output logic                 valid,
   output logic                 keep,
   output spq_pkg::entry_type   entry
);
   import spq_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   entry_type entry_ff;
   entry_type entry_in;

   // An occupied cell whose priority does not exceed the new one stays put, so
   // equal priorities keep their arrival order.
   assign keep  = valid_ff && (entry_ff.prio <= cmd.entry.prio);
   assign valid = valid_ff;
   assign entry = entry_ff;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  valid_in = 1'b1;
                  entry_in = cmd.entry;
               end else begin
                  valid_in = left_valid;
                  entry_in = left_entry;
               end
            end
         end
         OP_REMOVE: begin
            valid_in = right_valid;
            entry_in = right_entry;
         end
         OP_ROTATE: begin
            // The tail cell takes the head, so the occupied cells turn round.
            if (valid_ff) begin
               entry_in = right_valid ? right_entry : head_entry;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_data: mode, value, priority_req
// rsp      out        rsp_valid / rsp_ready  rsp_data: status, value_res, priority_out, last
//
// Insert and remove update every cell of the chain in parallel.
// A list request first moves the control to the list state; then the chain rotates
// by one place for each result, and the output register sets the pace.
// Reset empties the queue at once; entry contents are not cleared.
// A stalled result holds the output register and the chain waits with it.

module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type      state_ff;
   state_type      state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] left_ff;
   logic [CNT_W-1:0] left_in;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;
   rsp_type        rsp_in;
   logic           rsp_load;
   logic           rsp_free;
   logic           accept;
   cell_cmd_type   cmd;

   logic      valid_w [CAPACITY];
   logic      keep_w  [CAPACITY];
   entry_type entry_w [CAPACITY];

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic      l_valid;
         logic      l_keep;
         entry_type l_entry;
         logic      r_valid;
         entry_type r_entry;

         if (i == 0) begin : g_first
            assign l_valid = 1'b0;
            assign l_keep  = 1'b1;
            assign l_entry = cmd.entry;
         end else begin : g_mid
            assign l_valid = valid_w[i-1];
            assign l_keep  = keep_w[i-1];
            assign l_entry = entry_w[i-1];
         end

         if (i == CAPACITY - 1) begin : g_last
            assign r_valid = 1'b0;
            assign r_entry = entry_w[0];
         end else begin : g_inner
            assign r_valid = valid_w[i+1];
            assign r_entry = entry_w[i+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .left_valid  (l_valid),
            .left_keep   (l_keep),
            .left_entry  (l_entry),
            .right_valid (r_valid),
            .right_entry (r_entry),
            .head_entry  (entry_w[0]),
            .valid       (valid_w[i]),
            .keep        (keep_w[i]),
            .entry       (entry_w[i])
         );
      end
   endgenerate

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in             = state_ff;
      count_in             = count_ff;
      left_in              = left_ff;
      rsp_load             = 1'b0;
      rsp_in               = '0;
      cmd.op               = OP_HOLD;
      cmd.entry.value      = req_data.value;
      cmd.entry.prio       = req_data.priority_req;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  MODE_INSERT: begin
                     rsp_load    = 1'b1;
                     rsp_in.last = 1'b1;
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        rsp_in.status = STATUS_OK;
                        cmd.op        = OP_INSERT;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_REMOVE: begin
                     rsp_load    = 1'b1;
                     rsp_in.last = 1'b1;
                     if (count_ff == '0) begin
                        rsp_in.status = STATUS_UNDERFLOW;
                     end else begin
                        rsp_in.status       = STATUS_OK;
                        rsp_in.value_res    = entry_w[0].value;
                        rsp_in.priority_out = entry_w[0].prio;
                        cmd.op              = OP_REMOVE;
                        count_in            = count_ff - CNT_W'(1);
                     end
                  end
                  MODE_LIST: begin
                     if (count_ff == '0) begin
                        rsp_load      = 1'b1;
                        rsp_in.last   = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        state_in = ST_LIST;
                        left_in  = count_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LIST: begin
            if (rsp_free) begin
               rsp_load            = 1'b1;
               rsp_in.status       = STATUS_OK;
               rsp_in.value_res    = entry_w[0].value;
               rsp_in.priority_out = entry_w[0].prio;
               rsp_in.last         = (left_ff == CNT_W'(1));
               cmd.op              = OP_ROTATE;
               left_in             = left_ff - CNT_W'(1);
               if (left_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
